FILE: design/qer_pkg.sv
// Shared constants, register indexes and types of the quadratic evaluator and root solver.
`timescale 1ns / 1ps

package qer_pkg;

    // default number format: signed Q16.16
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_C = 2'd2;

    // root count codes
    localparam logic [1:0] ROOTS_NONE   = 2'd0;
    localparam logic [1:0] ROOTS_SINGLE = 2'd1;
    localparam logic [1:0] ROOTS_PAIR   = 2'd2;

    // root solver sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DISC,
        S_CLASS,
        S_SQRT,
        S_PREP,
        S_DIV,
        S_STORE
    } t_seq_state;

    // status handed from the root solver to the output stage
    typedef struct packed {
        logic [1:0] count;
        logic       clipped;
        logic       bad;
    } t_root_flags;

endpackage

FILE: design/quadratic_eval_and_roots_core.sv
// Top level: coefficient registers, Horner cell chain for the value, root solver, output stage.
//
//  channel   direction  handshake               payload
//  command   in         i_start, o_busy         i_x_value
//  result    out        o_valid (strobe)        o_poly_value .. o_bad_coefficient
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A command is taken at each edge with i_start high and o_busy low, one per cycle;
// its result strobes after two cells of two steps each and one output step.
// Roots depend only on the coefficients: after reset and after each register write the
// solver runs through the discriminant, the square root and two divisions (one square root
// bit and one quotient bit per cycle), or stops after classifying when a is zero or the
// discriminant is negative, with o_busy and o_cfg_ready held off meanwhile.
// Reset is synchronous, active low. The receiver cannot stall: each result shows once.
`timescale 1ns / 1ps

module quadratic_eval_and_roots_core
    import qer_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [WORD_BITS-1:0] i_x_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_poly_value,
    output logic                        o_value_clipped,
    output logic [1:0]                  o_root_count,
    output logic signed [WORD_BITS-1:0] o_root_plus,
    output logic signed [WORD_BITS-1:0] o_root_minus,
    output logic                        o_roots_clipped,
    output logic                        o_bad_coefficient
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int TM  = (2 * W - 2 > W - 1 + F) ? (2 * W - 2) : (W - 1 + F);
    localparam int TW  = TM + 3;
    localparam int PM  = (TW + W > W + 2 * F) ? (TW + W) : (W + 2 * F);
    localparam int PW  = PM + 2;
    localparam logic signed [PW-1:0] RND  = PW'(1) << (2 * F - 1);
    localparam logic signed [PW-1:0] PMAX = PW'($signed({1'b0, {(W - 1){1'b1}}}));
    localparam logic signed [PW-1:0] PMIN = PW'($signed({1'b1, {(W - 1){1'b0}}}));

    logic signed [W-1:0]  r_coef_a, r_coef_b, r_coef_c;
    logic                 r_init;
    logic                 seq_busy;
    logic                 cfg_wr;
    logic                 accept;
    t_root_flags          flags;
    logic [W-1:0]         root_p, root_m;

    logic                 c1_valid, c2_valid;
    logic signed [W-1:0]  c1_x;
    logic signed [TW-1:0] c1_acc;
    logic signed [PW-1:0] c2_acc;
    logic signed [PW-1:0] p_round, p_shift;
    logic signed [W-1:0]  n_poly;
    logic                 n_vclip;

    logic                 r_valid;
    logic signed [W-1:0]  r_poly;
    logic                 r_vclip;
    t_root_flags          r_flags;
    logic [W-1:0]         r_rp, r_rm;

    assign o_busy      = seq_busy | r_init;
    assign o_cfg_ready = ~o_busy;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign accept      = i_start & ~o_busy;

    // hold coefficients; kick the solver once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= W'(1) << F;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_init   <= 1'b1;
        end else begin
            r_init <= 1'b0;
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_COEF_A: r_coef_a <= i_cfg_data;
                    REG_COEF_B: r_coef_b <= i_cfg_data;
                    REG_COEF_C: r_coef_c <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    qer_root_seq #(
        .W(W),
        .F(F)
    ) u_root_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kick       (cfg_wr | r_init),
        .i_coef_a     (r_coef_a),
        .i_coef_b     (r_coef_b),
        .i_coef_c     (r_coef_c),
        .o_busy       (seq_busy),
        .o_flags      (flags),
        .o_root_plus  (root_p),
        .o_root_minus (root_m)
    );

    // first cell: a * x + b * 2^F
    qer_horner_cell #(
        .W(W),
        .AW(TW),
        .OUT_W(TW)
    ) u_cell_1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_x      (i_x_value),
        .i_acc    (TW'(r_coef_a)),
        .i_addend (TW'(r_coef_b) <<< F),
        .o_valid  (c1_valid),
        .o_x      (c1_x),
        .o_acc    (c1_acc)
    );

    // second cell: t * x + c * 2^(2F)
    qer_horner_cell #(
        .W(W),
        .AW(TW),
        .OUT_W(PW)
    ) u_cell_2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c1_valid),
        .i_x      (c1_x),
        .i_acc    (c1_acc),
        .i_addend (PW'(r_coef_c) <<< (2 * F)),
        .o_valid  (c2_valid),
        .o_x      (),
        .o_acc    (c2_acc)
    );

    // round to nearest, drop fraction bits, saturate
    assign p_round = c2_acc + RND;
    assign p_shift = p_round >>> (2 * F);
    always_comb begin
        n_vclip = 1'b0;
        n_poly  = p_shift[W-1:0];
        if (p_shift > PMAX) begin
            n_vclip = 1'b1;
            n_poly  = PMAX[W-1:0];
        end else if (p_shift < PMIN) begin
            n_vclip = 1'b1;
            n_poly  = PMIN[W-1:0];
        end
    end

    // output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= c2_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_poly  <= n_poly;
        r_vclip <= n_vclip;
        r_flags <= flags;
        r_rp    <= root_p;
        r_rm    <= root_m;
    end

    assign o_valid           = r_valid;
    assign o_poly_value      = r_poly;
    assign o_value_clipped   = r_vclip;
    assign o_root_count      = r_flags.count;
    assign o_root_plus       = r_rp;
    assign o_root_minus      = r_rm;
    assign o_roots_clipped   = r_flags.clipped;
    assign o_bad_coefficient = r_flags.bad;

    // a taken command strobes its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##5 o_valid)
        else $error("result strobe missing after command");

    // a zero quadratic coefficient reports no roots
    a_bad_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_coefficient) |-> (o_root_count == ROOTS_NONE && !o_roots_clipped))
        else $error("roots reported with zero coefficient a");

    // a register write starts the solver
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_busy)
        else $error("solver not running after register write");

endmodule

FILE: design/qer_horner_cell.sv
// One Horner cell: acc * x + addend over two registered steps, passing x along the chain.
`timescale 1ns / 1ps

module qer_horner_cell
    import qer_pkg::*;
#(
    parameter int W     = WORD_BITS_DEF,
    parameter int AW    = 2 * WORD_BITS_DEF + 1,
    parameter int OUT_W = 2 * WORD_BITS_DEF + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [W-1:0]     i_x,
    input  logic signed [AW-1:0]    i_acc,
    input  logic signed [OUT_W-1:0] i_addend,
    output logic                    o_valid,
    output logic signed [W-1:0]     o_x,
    output logic signed [OUT_W-1:0] o_acc
);

    logic signed [2*W:0]    n_pp_lo;
    logic signed [AW-1:0]   n_pp_hi;
    logic signed [2*W:0]    r_pp_lo;
    logic signed [AW-1:0]   r_pp_hi;
    logic signed [W-1:0]    r_x1;
    logic                   r_v1;
    logic signed [OUT_W-1:0] n_sum;
    logic signed [OUT_W-1:0] r_sum;
    logic signed [W-1:0]    r_x2;
    logic                   r_v2;

    // split the accumulator into a low limb and a signed high part
    assign n_pp_lo = $signed({1'b0, i_acc[W-1:0]}) * i_x;
    assign n_pp_hi = $signed(i_acc[AW-1:W]) * i_x;

    // recombine partial products and add the coefficient term
    assign n_sum = (OUT_W'(r_pp_hi) << W) + OUT_W'(r_pp_lo) + i_addend;

    // advance control along the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // advance payload along the chain
    always_ff @(posedge i_clk) begin
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_x1    <= i_x;
        r_sum   <= n_sum;
        r_x2    <= r_x1;
    end

    assign o_valid = r_v2;
    assign o_x     = r_x2;
    assign o_acc   = r_sum;

endmodule

FILE: design/qer_root_seq.sv
// Root solver: discriminant, bit-serial square root and shared restoring divider.
`timescale 1ns / 1ps

module qer_root_seq
    import qer_pkg::*;
#(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_kick,
    input  logic signed [W-1:0] i_coef_a,
    input  logic signed [W-1:0] i_coef_b,
    input  logic signed [W-1:0] i_coef_c,
    output logic                o_busy,
    output t_root_flags         o_flags,
    output logic [W-1:0]        o_root_plus,
    output logic [W-1:0]        o_root_minus
);

    localparam int DW   = 2 * W + 3;      // discriminant
    localparam int SQW  = 2 * W + 2;      // square root operand
    localparam int RTW  = W + 1;          // square root result
    localparam int RW   = W + 4;          // square root remainder
    localparam int NW   = W + 3;          // root numerator -b +/- s
    localparam int NUMW = NW + F + 2;     // scaled dividend and quotient
    localparam int DVW  = W + 3;          // divider remainder and divisor
    localparam int ITW  = $clog2(NUMW + 1);
    localparam logic [NUMW-1:0] QMAX = {{(NUMW - W + 1){1'b0}}, {(W - 1){1'b1}}};

    t_seq_state r_state, n_state;

    logic signed [2*W-1:0] r_bb, r_ac;
    logic signed [DW-1:0]  r_d;
    logic [SQW-1:0]        r_sq;
    logic [RW-1:0]         r_rem;
    logic [RTW-1:0]        r_root;
    logic [ITW-1:0]        r_it;
    logic                  r_second;
    logic                  r_single;
    logic                  r_clip;
    logic [NUMW-1:0]       r_num;
    logic [NUMW-1:0]       r_quo;
    logic [DVW-1:0]        r_dv_rem;
    logic                  r_neg;
    t_root_flags           r_flags;
    logic [W-1:0]          r_rp, r_rm;

    logic                  a_zero;
    logic [W-1:0]          a_mag;
    logic [DVW-1:0]        den;
    logic [RW-1:0]         sq_sh, sq_trial;
    logic                  sq_ge;
    logic signed [NW-1:0]  n_b, n_s, n_n;
    logic [NW-1:0]         n_mag;
    logic [NUMW-1:0]       n_num;
    logic [DVW-1:0]        dv_sh;
    logic                  dv_ge;
    logic [W-1:0]          sat_val;
    logic                  sat_clip;
    logic                  last_it;

    assign a_zero  = (i_coef_a == '0);
    assign a_mag   = i_coef_a[W-1] ? W'(-i_coef_a) : W'(i_coef_a);
    assign den     = {1'b0, a_mag, 2'b00};
    assign last_it = (r_it == ITW'(1));

    // square root step: two operand bits per cycle
    assign sq_sh    = {r_rem[RW-3:0], r_sq[SQW-1:SQW-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    // numerator of the current root and its scaled dividend
    assign n_b   = NW'(i_coef_b);
    assign n_s   = $signed({2'b00, r_root});
    assign n_n   = r_second ? (-n_b - n_s) : (-n_b + n_s);
    assign n_mag = n_n[NW-1] ? NW'(-n_n) : NW'(n_n);
    assign n_num = (NUMW'(n_mag) << (F + 1)) + (NUMW'(a_mag) << 1);

    // restoring divide step: one quotient bit per cycle
    assign dv_sh = {r_dv_rem[DVW-2:0], r_num[NUMW-1]};
    assign dv_ge = (dv_sh >= den);

    // apply sign and saturate the quotient
    always_comb begin
        sat_clip = 1'b0;
        sat_val  = r_quo[W-1:0];
        if (r_neg) begin
            if (r_quo > QMAX + NUMW'(1)) begin
                sat_clip = 1'b1;
                sat_val  = {1'b1, {(W - 1){1'b0}}};
            end else begin
                sat_val = W'(~r_quo + NUMW'(1));
            end
        end else if (r_quo > QMAX) begin
            sat_clip = 1'b1;
            sat_val  = {1'b0, {(W - 1){1'b1}}};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_kick) n_state = S_MUL;
            S_MUL:   n_state = S_DISC;
            S_DISC:  n_state = S_CLASS;
            S_CLASS: n_state = (a_zero || r_d[DW-1]) ? S_IDLE : S_SQRT;
            S_SQRT:  if (last_it) n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (last_it) n_state = S_STORE;
            S_STORE: n_state = r_second ? S_IDLE : S_PREP;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            S_IDLE:  o_busy = 1'b0;
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath of the solver
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: begin
                r_bb <= i_coef_b * i_coef_b;
                r_ac <= i_coef_a * i_coef_c;
            end
            S_DISC: begin
                r_d <= DW'(r_bb) - (DW'(r_ac) <<< 2);
            end
            S_CLASS: begin
                r_sq     <= r_d[SQW-1:0];
                r_rem    <= '0;
                r_root   <= '0;
                r_it     <= ITW'(RTW);
                r_second <= 1'b0;
                r_clip   <= 1'b0;
                r_single <= (r_d == '0);
                if (a_zero || r_d[DW-1]) begin
                    r_flags.count   <= ROOTS_NONE;
                    r_flags.clipped <= 1'b0;
                    r_flags.bad     <= a_zero;
                    r_rp            <= '0;
                    r_rm            <= '0;
                end
            end
            S_SQRT: begin
                r_rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                r_root <= {r_root[RTW-2:0], sq_ge};
                r_sq   <= r_sq << 2;
                r_it   <= r_it - ITW'(1);
            end
            S_PREP: begin
                r_num    <= n_num;
                r_neg    <= n_n[NW-1] != i_coef_a[W-1];
                r_dv_rem <= '0;
                r_quo    <= '0;
                r_it     <= ITW'(NUMW);
            end
            S_DIV: begin
                r_dv_rem <= dv_ge ? (dv_sh - den) : dv_sh;
                r_quo    <= {r_quo[NUMW-2:0], dv_ge};
                r_num    <= r_num << 1;
                r_it     <= r_it - ITW'(1);
            end
            S_STORE: begin
                if (!r_second) begin
                    r_rp     <= sat_val;
                    r_clip   <= sat_clip;
                    r_second <= 1'b1;
                end else begin
                    r_rm            <= sat_val;
                    r_flags.count   <= r_single ? ROOTS_SINGLE : ROOTS_PAIR;
                    r_flags.clipped <= r_clip | sat_clip;
                    r_flags.bad     <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_flags      = r_flags;
    assign o_root_plus  = r_rp;
    assign o_root_minus = r_rm;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the quadratic evaluator and root solver core.
`timescale 1ns / 1ps

module testbench;
    import qer_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WB = WORD_BITS_DEF;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1450;

    typedef logic signed [191:0] t_wide;
    typedef logic signed [WB-1:0] t_word;

    typedef struct packed {
        t_word      poly;
        logic       vclip;
        logic [1:0] count;
        t_word      rplus;
        t_word      rminus;
        logic       rclip;
        logic       bad;
    } t_quad_result;

    typedef struct {
        t_word        a;
        t_word        b;
        t_word        c;
        t_word        x;
        bit           typed;
        t_quad_result res;
    } t_row;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    t_word      x_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [WB-1:0] cfg_data;
    logic       res_valid;
    t_word      poly_value;
    logic       value_clipped;
    logic [1:0] root_count;
    t_word      root_plus;
    t_word      root_minus;
    logic       roots_clipped;
    logic       bad_coefficient;

    // coefficient copy kept alongside the block
    t_word coef_a_q, coef_b_q, coef_c_q;
    t_quad_result pending_results[$];
    int errors, items_sent, results_seen, cfg_writes, stall_cycles;
    int count_hist[3];
    bit idle_on;

    quadratic_eval_and_roots_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_x_value(x_value), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .o_valid(res_valid),
        .o_poly_value(poly_value), .o_value_clipped(value_clipped),
        .o_root_count(root_count), .o_root_plus(root_plus), .o_root_minus(root_minus),
        .o_roots_clipped(roots_clipped), .o_bad_coefficient(bad_coefficient)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // clamp to the word range, flag when clamped
    function automatic t_word clamp_word(t_wide v, inout logic clip);
        t_wide hi, lo;
        hi = t_wide'((64'sd1 <<< (WB - 1)) - 1);
        lo = -t_wide'(64'sd1 <<< (WB - 1));
        if (v > hi) begin
            clip = 1'b1;
            return t_word'(hi);
        end
        if (v < lo) begin
            clip = 1'b1;
            return t_word'(lo);
        end
        return t_word'(v);
    endfunction

    // n * 2^F / (2a), nearest with ties away from zero
    function automatic t_word root_div(t_wide n, t_wide a, inout logic clip);
        bit neg;
        t_wide nm, am, q;
        neg = (n < 0) != (a < 0);
        nm = (n < 0) ? -n : n;
        am = (a < 0) ? -a : a;
        q = ((nm <<< (FB + 1)) + (am <<< 1)) / (am <<< 2);
        if (neg) q = -q;
        return clamp_word(q, clip);
    endfunction

    function automatic t_quad_result solve_quadratic(t_word ra, t_word rb, t_word rc,
                                                     t_word rx);
        t_wide a, b, c, x, p, d, s, t, one;
        t_quad_result r;
        a = ra; b = rb; c = rc; x = rx;
        one = 1;
        r = '0;
        p = a * x * x + ((b * x) <<< FB) + (c <<< (2 * FB)) + (one <<< (2 * FB - 1));
        p = p >>> (2 * FB);
        r.poly = clamp_word(p, r.vclip);
        if (a == 0) begin
            r.bad = 1'b1;
        end else begin
            d = b * b - 4 * a * c;
            if (d >= 0) begin
                s = 0;
                for (int k = WB + 1; k >= 0; k--) begin
                    t = s | (one <<< k);
                    if (t * t <= d) s = t;
                end
                r.count = (d == 0) ? ROOTS_SINGLE : ROOTS_PAIR;
                r.rplus  = root_div(-b + s, a, r.rclip);
                r.rminus = root_div(-b - s, a, r.rclip);
            end
        end
        return r;
    endfunction

    // register write, only with nothing in flight
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, t_word val);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_COEF_A: coef_a_q = val;
            REG_COEF_B: coef_b_q = val;
            REG_COEF_C: coef_c_q = val;
            default: ;
        endcase
    endtask

    task automatic set_coefs(t_word a, t_word b, t_word c);
        if (a != coef_a_q) write_reg(REG_COEF_A, a);
        if (b != coef_b_q) write_reg(REG_COEF_B, b);
        if (c != coef_c_q) write_reg(REG_COEF_C, c);
    endtask

    // hold a command until the block takes it, then queue its result
    task automatic send_x(t_word x, bit typed, t_quad_result typed_res);
        if (idle_on && $urandom_range(99) < 30) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        x_value <= x;
        do @(posedge clk); while (busy);
        pending_results.push_back(typed ? typed_res
                                  : solve_quadratic(coef_a_q, coef_b_q, coef_c_q, x));
        items_sent++;
    endtask

    function automatic t_word pick_word(int mode);
        t_word pool[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                           32'hFFFF_FFFF, 32'h0001_0000};
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            default: return pool[$urandom_range(0, 5)];
        endcase
    endfunction

    // check each result against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && res_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, poly %h", $time, poly_value);
            end else begin
                t_quad_result e;
                e = pending_results.pop_front();
                if (e.count <= ROOTS_PAIR) count_hist[e.count]++;
                if (poly_value !== e.poly) begin
                    errors++;
                    $display("%0t: poly_value exp %h got %h", $time, e.poly, poly_value);
                end
                if (value_clipped !== e.vclip) begin
                    errors++;
                    $display("%0t: value_clipped exp %b got %b", $time, e.vclip,
                             value_clipped);
                end
                if (root_count !== e.count) begin
                    errors++;
                    $display("%0t: root_count exp %0d got %0d", $time, e.count, root_count);
                end
                if (root_plus !== e.rplus) begin
                    errors++;
                    $display("%0t: root_plus exp %h got %h", $time, e.rplus, root_plus);
                end
                if (root_minus !== e.rminus) begin
                    errors++;
                    $display("%0t: root_minus exp %h got %h", $time, e.rminus, root_minus);
                end
                if (roots_clipped !== e.rclip) begin
                    errors++;
                    $display("%0t: roots_clipped exp %b got %b", $time, e.rclip,
                             roots_clipped);
                end
                if (bad_coefficient !== e.bad) begin
                    errors++;
                    $display("%0t: bad_coefficient exp %b got %b", $time, e.bad,
                             bad_coefficient);
                end
            end
        end
    end

    // watchdog: abort when no transaction moves for too long
    always @(posedge clk) begin
        if ((start && !busy) || res_valid || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_quad_result z;
        t_word a, b, c, x;
        int phase, left, k, m;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        x_value = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COEF_A;
        cfg_data = '0;
        errors = 0; items_sent = 0; results_seen = 0; cfg_writes = 0; stall_cycles = 0;
        count_hist = '{0, 0, 0};
        coef_a_q = t_word'(1 <<< FB);
        coef_b_q = '0;
        coef_c_q = '0;
        idle_on = 1'b1;
        z = '0;

        // directed rows: reset coefficients, extremes, zero a, each discriminant sign
        rows.push_back('{32'h10000, 0, 0, 0, 1, '{0, 0, ROOTS_SINGLE, 0, 0, 0, 0}});
        rows.push_back('{32'h10000, 0, 0, 32'h10000, 1,
                         '{32'h10000, 0, ROOTS_SINGLE, 0, 0, 0, 0}});
        rows.push_back('{32'h10000, 0, 0, 32'h7FFF_FFFF, 1,
                         '{32'h7FFF_FFFF, 1, ROOTS_SINGLE, 0, 0, 0, 0}});
        rows.push_back('{32'h10000, 0, 0, 32'h8000_0000, 1,
                         '{32'h7FFF_FFFF, 1, ROOTS_SINGLE, 0, 0, 0, 0}});
        rows.push_back('{0, 0, 0, 5, 1, '{0, 0, ROOTS_NONE, 0, 0, 0, 1}});
        rows.push_back('{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, z});
        rows.push_back('{32'h10000, 0, 32'h10000, 0, 1,
                         '{32'h10000, 0, ROOTS_NONE, 0, 0, 0, 0}});
        rows.push_back('{32'h10000, 0, 32'hFFFF_0000, 0, 1,
                         '{32'hFFFF_0000, 0, ROOTS_PAIR, 32'h10000, 32'hFFFF_0000, 0, 0}});
        rows.push_back('{32'h10000, 0, 32'hFFFF_0000, 32'h0003_8000, 0, z});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, z});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, z});
        rows.push_back('{1, 32'h7FFF_FFFF, 0, 32'h1234_5678, 0, z});
        rows.push_back('{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 0, z});
        rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 0, z});
        rows.push_back('{32'h20000, 32'hFFFC_0000, 32'h20000, 32'h10000, 0, z});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            set_coefs(rows[i].a, rows[i].b, rows[i].c);
            send_x(rows[i].x, rows[i].typed, rows[i].res);
        end
        start <= 1'b0;
        write_reg(REG_UNUSED, t_word'($urandom));

        // random phases: new coefficients, then a burst of x values
        phase = 0;
        left = RANDOM_ITEMS;
        while (left > 0) begin
            idle_on = !(phase >= 4 && phase <= 6);
            if ($urandom_range(3) == 0) begin
                // repeated root: b*b == 4*a*c with small integers
                k = $urandom_range(1, 300) * ($urandom_range(1) ? 1 : -1);
                m = int'($urandom_range(0, 400)) - 200;
                a = t_word'(k);
                b = t_word'(-2 * k * m);
                c = t_word'(k * m * m);
            end else begin
                a = pick_word($urandom_range(0, 2));
                b = pick_word($urandom_range(0, 2));
                c = pick_word($urandom_range(0, 2));
            end
            start <= 1'b0;
            if (phase == 0) set_coefs(t_word'($urandom), t_word'($urandom), t_word'($urandom));
            set_coefs(a, b, c);
            if ($urandom_range(3) == 0) write_reg(REG_UNUSED, t_word'($urandom));
            repeat ($urandom_range(40, 120)) begin
                if (left > 0) begin
                    x = pick_word($urandom_range(0, 9) < 5 ? 0
                                  : ($urandom_range(0, 3) == 0 ? 2 : 1));
                    send_x(x, 1'b0, z);
                    left--;
                end
            end
            phase++;
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d x values over %0d phases, %0d register writes.",
                 items_sent, phase, cfg_writes);
        $display("Results checked: %0d (no roots %0d, one root %0d, two roots %0d).",
                 results_seen, count_hist[0], count_hist[1], count_hist[2]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
